[rtl/priority_request_queue_with_limits_assert.svh]
// Assertion macros shared by the queue modules.
`ifndef PRIORITY_REQUEST_QUEUE_WITH_LIMITS_ASSERT_SVH
`define PRIORITY_REQUEST_QUEUE_WITH_LIMITS_ASSERT_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define PRQ_ASSERT_IMP(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert that an antecedent implies a consequent in the next cycle.
`define PRQ_ASSERT_NXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/prql_pkg.sv]
`timescale 1ns / 1ps
package prql_pkg;
    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 16;
    localparam int TAG_BITS      = 8;
    localparam int IDX_BITS      = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes.
    localparam logic [1:0] OP_ENQ    = 2'd0;
    localparam logic [1:0] OP_SEND   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_EXPIRE = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DROPPED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_SENT  = 3'd4;
    localparam logic [2:0] ST_SENT      = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND = 3'd6;
    localparam logic [2:0] ST_IN_FLIGHT = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the request
        logic scan_clr;   // reset the scan index
        logic scan_step;  // advance the scan index
        logic sh_up;      // shift entries up at the shift pointer (insert)
        logic sh_down;    // shift entries down from the shift pointer (remove)
        logic ins_write;  // write the new entry at the insert position
        logic ev_scan;    // advance the eviction scan
        logic fin;        // present the result
    } prql_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       scan_end;  // ordering or tag scan has finished
        logic       ev_end;    // eviction scan has finished
        logic       sh_end;    // shift has reached its end
    } prql_sts_t;
endpackage

[rtl/prql_ctrl.sv]
`timescale 1ns / 1ps
`include "priority_request_queue_with_limits_assert.svh"
module prql_ctrl
    import prql_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  prql_sts_t sts,
    output prql_cmd_t cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHUP  = 3'd2;
    localparam logic [2:0] S_EVSC  = 3'd3;
    localparam logic [2:0] S_SHDN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_DONE;
                    if (sts.op == OP_ENQ)
                        state_next = S_SHUP;
                    else if (sts.op != OP_SEND)
                        state_next = S_SHDN;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_SHUP:
            begin
                if (sts.sh_end)
                begin
                    cmd.ins_write = 1'b1;
                    state_next    = S_EVSC;
                end
                else
                    cmd.sh_up = 1'b1;
            end
            S_EVSC:
            begin
                if (sts.ev_end)
                    state_next = S_SHDN;
                else
                    cmd.ev_scan = 1'b1;
            end
            S_SHDN:
            begin
                if (sts.sh_end)
                    state_next = S_DONE;
                else
                    cmd.sh_down = 1'b1;
            end
            S_DONE:
            begin
                cmd.fin    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    `PRQ_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `PRQ_ASSERT_NXT(a_fin_idle, clk, rst_n, cmd.fin, !busy)
    `PRQ_ASSERT_IMP(a_one_shift, clk, rst_n, cmd.sh_up, !cmd.sh_down && !cmd.ev_scan)
endmodule

[rtl/prql_dp.sv]
`timescale 1ns / 1ps
`include "priority_request_queue_with_limits_assert.svh"
module prql_dp
    import prql_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  prql_cmd_t            cmd,
    output prql_sts_t            sts,
    input  logic [1:0]           operation,
    input  logic [15:0]          priority_req,
    input  logic [4:0]           queue_limit,
    input  logic [7:0]           tag,
    output logic                 done,
    output logic [2:0]           status,
    output logic [7:0]           result_tag,
    output logic                 evicted,
    output logic [7:0]           evicted_tag,
    output logic [4:0]           queue_count,
    output logic                 head_valid,
    output logic [7:0]           head_tag
);
    // Entry store, kept in queue order from the head at index 0.
    logic [PRIORITY_BITS-1:0] pri_reg [QUEUE_DEPTH];
    logic [4:0]               lim_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      tag_reg [QUEUE_DEPTH];

    logic [CNT_BITS-1:0]      count_reg;
    logic                     flight_reg;

    // Captured request and working registers.
    logic [1:0]               op_reg;
    logic [PRIORITY_BITS-1:0] rpri_reg;
    logic [4:0]               rlim_reg;
    logic [TAG_BITS-1:0]      rtag_reg;
    logic [CNT_BITS-1:0]      idx_reg;     // scan index
    logic [CNT_BITS-1:0]      pos_reg;     // insert or removal position
    logic [CNT_BITS-1:0]      sh_reg;      // shift pointer
    logic                     rm_reg;      // a removal is pending
    logic [2:0]               st_reg;
    logic [TAG_BITS-1:0]      res_reg;
    logic                     ev_reg;
    logic [TAG_BITS-1:0]      evt_reg;
    logic                     done_reg;

    logic [IDX_BITS-1:0]      idx_i, sh_i;
    logic                     full;
    logic                     pos_lim;
    logic                     ev_hit;

    // Outcome of the first scan, taken in its final cycle.
    logic                     sts_take, rm_val, fl_set, fl_clr;
    logic [2:0]               st_val;
    logic                     scan_phase_reg;

    assign idx_i   = idx_reg[IDX_BITS-1:0];
    assign sh_i    = sh_reg[IDX_BITS-1:0];
    assign full    = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign pos_lim = ({{(8-CNT_BITS > 0 ? 8-CNT_BITS : 0){1'b0}}, idx_reg} >= 8'(rlim_reg));
    assign ev_hit  = (CNT_BITS'(lim_reg[idx_i]) < count_reg);

    // Scan termination per operation.
    always_comb
    begin
        sts.op       = op_reg;
        sts.scan_end = 1'b1;
        unique case (op_reg)
            OP_ENQ:
                sts.scan_end = (idx_reg >= count_reg) || pos_lim
                               || (pri_reg[idx_i] < rpri_reg);
            OP_EXPIRE:
                sts.scan_end = (idx_reg >= count_reg) || (tag_reg[idx_i] == rtag_reg);
            default:
                sts.scan_end = 1'b1;
        endcase
        sts.ev_end = (idx_reg >= count_reg) || ev_reg || (st_reg != ST_OK);
        // A rejected request leaves the store untouched.
        if (st_reg != ST_OK)
            sts.sh_end = 1'b1;
        else if (rm_reg)
            sts.sh_end = (sh_reg + 1'b1 >= count_reg);
        else
            sts.sh_end = (sh_reg <= pos_reg);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            flight_reg <= 1'b0;
            done_reg   <= 1'b0;
            rm_reg     <= 1'b0;
            st_reg     <= ST_OK;
            ev_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.fin;
            if (cmd.load)
            begin
                rm_reg <= 1'b0;
                ev_reg <= 1'b0;
                st_reg <= ST_OK;
            end
            if (cmd.ins_write && st_reg == ST_OK)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.ev_scan && ev_hit)
            begin
                ev_reg <= 1'b1;
                rm_reg <= 1'b1;
            end
            // The gap has been closed by the time the result is presented.
            if (cmd.fin && rm_reg)
            begin
                rm_reg    <= 1'b0;
                count_reg <= count_reg - 1'b1;
            end
            if (sts_take)
            begin
                st_reg <= st_val;
                rm_reg <= rm_val;
                if (fl_set)
                    flight_reg <= 1'b1;
                if (fl_clr)
                    flight_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_phase_reg <= 1'b0;
        else if (cmd.load)
            scan_phase_reg <= 1'b1;
        else if (sts_take)
            scan_phase_reg <= 1'b0;
    end

    assign sts_take = scan_phase_reg && sts.scan_end;

    always_comb
    begin
        st_val = ST_OK;
        rm_val = 1'b0;
        fl_set = 1'b0;
        fl_clr = 1'b0;
        unique case (op_reg)
            OP_ENQ:
            begin
                if (pos_lim)
                    st_val = ST_DROPPED;
                else if (full)
                    st_val = ST_FULL;
            end
            OP_SEND:
            begin
                if (count_reg == '0)
                    st_val = ST_EMPTY;
                else if (flight_reg)
                    st_val = ST_SENT;
                else
                    fl_set = 1'b1;
            end
            OP_FINISH:
            begin
                if (count_reg == '0)
                    st_val = ST_EMPTY;
                else if (!flight_reg)
                    st_val = ST_NOT_SENT;
                else
                begin
                    rm_val = 1'b1;
                    fl_clr = 1'b1;
                end
            end
            default:
            begin
                if (idx_reg >= count_reg)
                    st_val = ST_NOT_FOUND;
                else if (idx_reg == '0 && flight_reg)
                    st_val = ST_IN_FLIGHT;
                else
                    rm_val = 1'b1;
            end
        endcase
    end

    // Payload registers: request capture, indices, result and store.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            rpri_reg <= priority_req[PRIORITY_BITS-1:0];
            rlim_reg <= queue_limit;
            rtag_reg <= tag[TAG_BITS-1:0];
            res_reg  <= '0;
            evt_reg  <= '0;
        end
        if (cmd.scan_clr)
            idx_reg <= '0;
        else if (cmd.scan_step)
            idx_reg <= idx_reg + 1'b1;
        if (sts_take)
        begin
            case (op_reg)
                OP_ENQ:
                begin
                    sh_reg <= count_reg;
                    // Never go ahead of a head that is in flight.
                    if (idx_reg == '0 && count_reg != '0 && flight_reg)
                        pos_reg <= CNT_BITS'(1);
                    else
                        pos_reg <= idx_reg;
                end
                OP_FINISH:
                begin
                    pos_reg <= '0;
                    sh_reg  <= '0;
                end
                default:
                begin
                    pos_reg <= idx_reg;
                    sh_reg  <= idx_reg;
                end
            endcase
            if (st_val == ST_OK)
            begin
                case (op_reg) inside
                    OP_SEND, OP_FINISH: res_reg <= tag_reg[0];
                    default:            res_reg <= rtag_reg;
                endcase
            end
        end
        // Open a gap: move one entry up per cycle.
        if (cmd.sh_up)
        begin
            pri_reg[sh_i] <= pri_reg[sh_i - 1'b1];
            lim_reg[sh_i] <= lim_reg[sh_i - 1'b1];
            tag_reg[sh_i] <= tag_reg[sh_i - 1'b1];
            sh_reg        <= sh_reg - 1'b1;
        end
        if (cmd.ins_write && st_reg == ST_OK)
        begin
            pri_reg[pos_reg[IDX_BITS-1:0]] <= rpri_reg;
            lim_reg[pos_reg[IDX_BITS-1:0]] <= rlim_reg;
            tag_reg[pos_reg[IDX_BITS-1:0]] <= rtag_reg;
            idx_reg <= pos_reg + 1'b1;
        end
        // Eviction scan behind the new entry.
        if (cmd.ev_scan)
        begin
            if (ev_hit)
            begin
                evt_reg <= tag_reg[idx_i];
                sh_reg  <= idx_reg;
            end
            else
                idx_reg <= idx_reg + 1'b1;
        end
        // Close a gap: move one entry down per cycle.
        if (cmd.sh_down)
        begin
            pri_reg[sh_i] <= pri_reg[sh_i + 1'b1];
            lim_reg[sh_i] <= lim_reg[sh_i + 1'b1];
            tag_reg[sh_i] <= tag_reg[sh_i + 1'b1];
            sh_reg        <= sh_reg + 1'b1;
        end
    end

    assign done        = done_reg;
    assign status      = st_reg;
    assign result_tag  = 8'(res_reg);
    assign evicted     = ev_reg;
    assign evicted_tag = 8'(evt_reg);
    assign queue_count = 5'(count_reg);
    assign head_valid  = (count_reg != '0);
    assign head_tag    = (count_reg != '0) ? 8'(tag_reg[0]) : 8'd0;

    `PRQ_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CNT_BITS'(QUEUE_DEPTH))
    `PRQ_ASSERT_IMP(a_flight_nonempty, clk, rst_n, flight_reg, count_reg != '0)
    `PRQ_ASSERT_IMP(a_evict_ok, clk, rst_n, done_reg && ev_reg, st_reg == ST_OK)
endmodule

[rtl/priority_request_queue_with_limits.sv]
`timescale 1ns / 1ps
// Ordered request queue of sixteen entries with per-request length limits.
// A request is taken when start is high and busy is low; its result appears
// for exactly one cycle with done high and cannot be held off. After the
// accepting edge a request scans the entries one at a time for ordering or
// tag match, shifts entries one at a time on insertion or removal, checks
// the entries behind a new one for eviction, and then presents the result,
// all through a single-entry shift datapath.
module priority_request_queue_with_limits
    import prql_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [15:0] priority_req,
    input  logic [4:0]  queue_limit,
    input  logic [7:0]  tag,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  result_tag,
    output logic        evicted,
    output logic [7:0]  evicted_tag,
    output logic [4:0]  queue_count,
    output logic        head_valid,
    output logic [7:0]  head_tag
);
    prql_cmd_t cmd;
    prql_sts_t sts;

    prql_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    prql_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (operation),
        .priority_req (priority_req),
        .queue_limit  (queue_limit),
        .tag          (tag),
        .done         (done),
        .status       (status),
        .result_tag   (result_tag),
        .evicted      (evicted),
        .evicted_tag  (evicted_tag),
        .queue_count  (queue_count),
        .head_valid   (head_valid),
        .head_tag     (head_tag)
    );
endmodule

[verif/prql_checker.sv]
`timescale 1ns / 1ps
// Watches the request and result channels of the queue, keeps its own copy of
// the queue contents and compares every result with the expected one.
module prql_checker
    import prql_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  operation,
    input  logic [15:0] priority_req,
    input  logic [4:0]  queue_limit,
    input  logic [7:0]  tag,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [7:0]  result_tag,
    input  logic        evicted,
    input  logic [7:0]  evicted_tag,
    input  logic [4:0]  queue_count,
    input  logic        head_valid,
    input  logic [7:0]  head_tag,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [2:0] st;
        logic [7:0] rtag;
        logic       ev;
        logic [7:0] evtag;
        logic [4:0] cnt;
        logic       hv;
        logic [7:0] htag;
    } queue_answer_t;

    logic [15:0] q_prio [QUEUE_DEPTH+1];
    logic [4:0]  q_lim  [QUEUE_DEPTH+1];
    logic [7:0]  q_tag  [QUEUE_DEPTH+1];
    int          q_len;
    logic        in_flight;
    queue_answer_t answers [$];

    initial fail_count = 0;
    assign pending = answers.size();

    // Print one line for a mismatch and count it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Remove the entry at a given position, closing the gap.
    function automatic void drop_entry(input int idx);
        for (int i = idx; i + 1 < q_len; i++)
        begin
            q_prio[i] = q_prio[i+1];
            q_lim[i]  = q_lim[i+1];
            q_tag[i]  = q_tag[i+1];
        end
        q_len--;
    endfunction

    // Apply one request to the queue copy and return the expected answer.
    function automatic queue_answer_t apply_request(input logic [1:0] op,
            input logic [15:0] prio, input logic [4:0] lim, input logic [7:0] tg);
        queue_answer_t a;
        int pos;
        a = '0;
        a.st = ST_OK;
        if (op == OP_ENQ)
        begin
            pos = 0;
            while (pos < q_len && pos < lim && q_prio[pos] >= prio)
                pos++;
            if (pos >= lim)
                a.st = ST_DROPPED;
            else if (q_len >= QUEUE_DEPTH)
                a.st = ST_FULL;
            else
            begin
                if (pos == 0 && q_len > 0 && in_flight)
                    pos = 1;
                for (int i = q_len; i > pos; i--)
                begin
                    q_prio[i] = q_prio[i-1];
                    q_lim[i]  = q_lim[i-1];
                    q_tag[i]  = q_tag[i-1];
                end
                q_prio[pos] = prio;
                q_lim[pos]  = lim;
                q_tag[pos]  = tg;
                q_len++;
                a.rtag = tg;
                // The first later entry whose limit is now exceeded goes.
                for (int i = pos + 1; i < q_len; i++)
                begin
                    if (q_lim[i] < q_len)
                    begin
                        a.ev = 1'b1;
                        a.evtag = q_tag[i];
                        drop_entry(i);
                        break;
                    end
                end
            end
        end
        else if (op == OP_SEND)
        begin
            if (q_len == 0)
                a.st = ST_EMPTY;
            else if (in_flight)
                a.st = ST_SENT;
            else
            begin
                in_flight = 1'b1;
                a.rtag = q_tag[0];
            end
        end
        else if (op == OP_FINISH)
        begin
            if (q_len == 0)
                a.st = ST_EMPTY;
            else if (!in_flight)
                a.st = ST_NOT_SENT;
            else
            begin
                a.rtag = q_tag[0];
                drop_entry(0);
                in_flight = 1'b0;
            end
        end
        else
        begin
            a.st = ST_NOT_FOUND;
            for (int i = 0; i < q_len; i++)
            begin
                if (q_tag[i] == tg)
                begin
                    if (i == 0 && in_flight)
                        a.st = ST_IN_FLIGHT;
                    else
                    begin
                        a.st = ST_OK;
                        a.rtag = tg;
                        drop_entry(i);
                    end
                    break;
                end
            end
        end
        a.cnt = q_len[4:0];
        a.hv = (q_len > 0);
        a.htag = (q_len > 0) ? q_tag[0] : 8'd0;
        return a;
    endfunction

    // Predict on each accepted request and compare each result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_len = 0;
            in_flight = 1'b0;
            answers.delete();
        end
        else
        begin
            if (done)
            begin
                if (answers.size() == 0)
                begin
                    $display("%0t result with no request outstanding", $time);
                    fail_count++;
                end
                else
                begin
                    queue_answer_t w;
                    w = answers.pop_front();
                    if (status !== w.st) report_mismatch("status", status, w.st);
                    if (result_tag !== w.rtag)
                        report_mismatch("result_tag", result_tag, w.rtag);
                    if (evicted !== w.ev) report_mismatch("evicted", evicted, w.ev);
                    if (evicted_tag !== w.evtag)
                        report_mismatch("evicted_tag", evicted_tag, w.evtag);
                    if (queue_count !== w.cnt)
                        report_mismatch("queue_count", queue_count, w.cnt);
                    if (head_valid !== w.hv)
                        report_mismatch("head_valid", head_valid, w.hv);
                    if (head_tag !== w.htag) report_mismatch("head_tag", head_tag, w.htag);
                end
            end
            if (start && !busy)
                answers.push_back(apply_request(operation, priority_req, queue_limit, tag));
        end
    end

endmodule

[verif/tb_priority_request_queue_with_limits.sv]
`timescale 1ns / 1ps
// Drives requests into the queue and gives the verdict from the checker.
module tb_priority_request_queue_with_limits;
    import prql_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = OP_ENQ;
    logic [15:0] priority_req = '0;
    logic [4:0]  queue_limit = '0;
    logic [7:0]  tag = '0;
    logic        done;
    logic [2:0]  status;
    logic [7:0]  result_tag;
    logic        evicted;
    logic [7:0]  evicted_tag;
    logic [4:0]  queue_count;
    logic        head_valid;
    logic [7:0]  head_tag;
    int          fail_count;
    int          pending;
    logic [7:0]  recent_tags [$];

    always #6 clk = ~clk;

    priority_request_queue_with_limits i_dut (.*);

    prql_checker i_checker (.*);

    // Hand one request over and wait until it is taken.
    task automatic issue_request(input logic [1:0] op, input logic [15:0] prio,
            input logic [4:0] lim, input logic [7:0] tg);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        repeat (gap) @(negedge clk);
        operation <= op;
        priority_req <= prio;
        queue_limit <= lim;
        tag <= tg;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start <= 1'b0;
        if (op == OP_ENQ)
        begin
            recent_tags.push_back(tg);
            if (recent_tags.size() > 12)
                void'(recent_tags.pop_front());
        end
    endtask

    // Random request, weighted towards realistic traffic.
    task automatic random_request();
        logic [1:0]  op;
        logic [15:0] prio;
        logic [7:0]  tg;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = OP_ENQ;
        else if (pick < 65)
            op = OP_SEND;
        else if (pick < 85)
            op = OP_FINISH;
        else
            op = OP_EXPIRE;
        // Few priority levels give many ties; sometimes the full range.
        prio = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        tg = 8'($urandom);
        if (op == OP_EXPIRE && recent_tags.size() > 0 && $urandom_range(0, 3) != 0)
            tg = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
        issue_request(op, prio, 5'($urandom_range(0, 16)), tg);
    endtask

    // Stimulus: directed cases first, then random traffic.
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        issue_request(OP_SEND, 16'd0, 5'd0, 8'd0);
        issue_request(OP_FINISH, 16'd0, 5'd0, 8'd0);
        issue_request(OP_EXPIRE, 16'd0, 5'd0, 8'hFF);
        issue_request(OP_ENQ, 16'hFFFF, 5'd0, 8'hAA);
        issue_request(OP_ENQ, 16'h0000, 5'd16, 8'h55);
        issue_request(OP_FINISH, 16'd0, 5'd0, 8'd0);
        issue_request(OP_SEND, 16'd0, 5'd0, 8'd0);
        issue_request(OP_SEND, 16'd0, 5'd0, 8'd0);
        issue_request(OP_ENQ, 16'hFFFF, 5'd16, 8'hFF);
        issue_request(OP_EXPIRE, 16'd0, 5'd0, 8'h55);
        issue_request(OP_ENQ, 16'h8000, 5'd1, 8'h01);
        issue_request(OP_ENQ, 16'h8000, 5'd1, 8'h02);
        issue_request(OP_FINISH, 16'd0, 5'd0, 8'd0);
        for (int i = 0; i < 17; i++)
            issue_request(OP_ENQ, 16'(i), 5'd16, 8'(i));
        issue_request(OP_ENQ, 16'd0, 5'd2, 8'h77);
        issue_request(OP_ENQ, 16'hFFFF, 5'd3, 8'h33);
        issue_request(OP_EXPIRE, 16'd0, 5'd0, 8'hEE);
        for (int i = 0; i < 900; i++)
            random_request();
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Time limit.
    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
